[rtl/core/column_pixel_blend_scaler_unit_macros.svh]
// assertion macros shared by the column pixel blend scaler rtl
// no dependencies; included by the top level only
`ifndef COLUMN_PIXEL_BLEND_SCALER_UNIT_MACROS_SVH
`define COLUMN_PIXEL_BLEND_SCALER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CPBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cpbs check failed");

// next-cycle implication, disabled while reset is low
`define CPBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cpbs check failed");

`endif

[rtl/core/cpbs_pkg.sv]
// shared types, codes and helpers for the column pixel blend scaler
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package cpbs_pkg;

    localparam int COLUMN_DEPTH = 256;
    localparam int CIDX_W       = $clog2(COLUMN_DEPTH);
    localparam int PAL_DEPTH    = 256;
    localparam int PIX_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 24;
    localparam int FRAC_BITS    = 16;
    localparam int PADDR_W      = 4;
    localparam logic [PIX_W-1:0] HALF_MASK = 32'h00fe_fefe;
    localparam logic [POS_W-1:0] STEP_RESET = 24'h01_0000;

    typedef enum logic [1:0] {
        OP_PALETTE = 2'd0,
        OP_TRANS   = 2'd1,
        OP_COLUMN  = 2'd2,
        OP_DRAW    = 2'd3
    } cpbs_op_t;

    typedef enum logic [2:0] {
        MODE_NORMAL      = 3'd0,
        MODE_BLEND       = 3'd1,
        MODE_TRANS       = 3'd2,
        MODE_TRANS_BLEND = 3'd3,
        MODE_FILL        = 3'd4,
        MODE_FILL_BLEND  = 3'd5
    } cpbs_mode_t;

    typedef enum logic [1:0] {
        REG_DRAW_MODE   = 2'd0,
        REG_FILL_COLOR  = 2'd1,
        REG_SOURCE_STEP = 2'd2
    } cpbs_reg_t;

    // one item as it travels down the pipe
    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        idx;
        logic [PIX_W-1:0]  val;
        logic [PIX_W-1:0]  bg;
    } cpbs_item_t;

    function automatic logic [PIX_W-1:0] half_blend(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        return ((a & HALF_MASK) >> 1) + ((b & HALF_MASK) >> 1);
    endfunction

    // column position wraps at the column depth
    function automatic logic [CIDX_W-1:0] col_index(input logic [7:0] x);
        logic [15:0] w;
        w = {8'd0, x};
        return CIDX_W'(w % COLUMN_DEPTH);
    endfunction

endpackage

[rtl/core/column_pixel_blend_scaler_unit.sv]
// top level of the column pixel blend scaler: apb registers, pipeline, three rams
// depends on cpbs_pkg, cpbs_ram and column_pixel_blend_scaler_unit_macros.svh
`timescale 1ns / 1ps
`include "column_pixel_blend_scaler_unit_macros.svh"

// Takes one item per clock while s_ready is high and puts a pixel on the result port
// for each accepted draw item. Each item walks through three synchronous rams
// in turn: the column store (read with the 8.16 source position), the translation
// map and the palette, each with a registered read, then a blend and output
// stage. Every store is written in the same stage where it is read, so writes and
// draws see each other in item order without forwarding. Stages advance on their
// own, so a stalled result does not stop new items while bubbles remain. The stores
// need no clearing after reset; configure registers only while the block is idle.
module column_pixel_blend_scaler_unit
    import cpbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_entry_index,
    input  logic [PIX_W-1:0]   s_write_value,
    input  logic [PIX_W-1:0]   s_background,
    input  logic               s_first_of_run,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel
);

    logic [2:0]       mode_reg;
    logic [PIX_W-1:0] fill_reg;
    logic [POS_W-1:0] step_reg;
    logic [POS_W-1:0] pos_reg, pos_next, pos_base;

    logic             v1_reg, v2_reg, v3_reg, out_v_reg;
    cpbs_item_t       s1_reg, s2_reg;
    logic [BYTE_W-1:0] s2_src_reg;
    logic [PIX_W-1:0] s3_bg_reg;
    logic [PIX_W-1:0] pixel_reg, pixel_next;

    logic en0, en1, en2, en3, acc, cfg_wr;
    logic translated;
    cpbs_item_t in_item;

    logic [BYTE_W-1:0] col_rdata, trans_rdata;
    logic [PIX_W-1:0]  pal_rdata;
    logic [CIDX_W-1:0] col_raddr;
    logic [BYTE_W-1:0] pal_raddr;

    // ---- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_DRAW_MODE:   prdata = {29'd0, mode_reg};
            REG_FILL_COLOR:  prdata = fill_reg;
            REG_SOURCE_STEP: prdata = {8'd0, step_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            fill_reg <= '0;
            step_reg <= STEP_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DRAW_MODE:   mode_reg <= pwdata[2:0];
                REG_FILL_COLOR:  fill_reg <= pwdata;
                REG_SOURCE_STEP: step_reg <= pwdata[POS_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---- stage enables: a stage moves when the next one is empty or moving
    always_comb begin
        en3 = !out_v_reg || m_ready;
        en2 = !v3_reg || en3;
        en1 = !v2_reg || en2;
        en0 = !v1_reg || en1;
    end

    assign s_ready = en0;
    assign acc     = s_valid && en0;

    assign in_item = '{op: s_operation, idx: s_entry_index,
                       val: s_write_value, bg: s_background};

    assign translated = (mode_reg == MODE_TRANS) || (mode_reg == MODE_TRANS_BLEND);

    // source position of this draw and the next
    assign pos_base  = s_first_of_run ? '0 : pos_reg;
    assign pos_next  = pos_base + step_reg;
    assign col_raddr = col_index(pos_base[POS_W-1:FRAC_BITS]);
    assign pal_raddr = translated ? trans_rdata : s2_src_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (acc && s_operation == OP_DRAW) begin
            pos_reg <= pos_next;
        end
    end

    // ---- stores
    cpbs_ram #(.WIDTH(BYTE_W), .DEPTH(COLUMN_DEPTH)) u_column_ram (
        .aclk  (aclk),
        .we    (acc && s_operation == OP_COLUMN),
        .waddr (col_index(s_entry_index)),
        .wdata (s_write_value[BYTE_W-1:0]),
        .re    (en0),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    cpbs_ram #(.WIDTH(BYTE_W), .DEPTH(PAL_DEPTH)) u_trans_ram (
        .aclk  (aclk),
        .we    (v1_reg && en1 && s1_reg.op == OP_TRANS),
        .waddr (s1_reg.idx),
        .wdata (s1_reg.val[BYTE_W-1:0]),
        .re    (en1),
        .raddr (col_rdata),
        .rdata (trans_rdata)
    );

    cpbs_ram #(.WIDTH(PIX_W), .DEPTH(PAL_DEPTH)) u_palette_ram (
        .aclk  (aclk),
        .we    (v2_reg && en2 && s2_reg.op == OP_PALETTE),
        .waddr (s2_reg.idx),
        .wdata (s2_reg.val),
        .re    (en2),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    // ---- output pixel
    always_comb begin
        case (mode_reg)
            MODE_BLEND:       pixel_next = half_blend(pal_rdata, s3_bg_reg);
            MODE_TRANS:       pixel_next = pal_rdata;
            MODE_TRANS_BLEND: pixel_next = half_blend(pal_rdata, s3_bg_reg);
            MODE_FILL:        pixel_next = fill_reg;
            MODE_FILL_BLEND:  pixel_next = half_blend(fill_reg, s3_bg_reg);
            default:          pixel_next = pal_rdata;
        endcase
    end

    // ---- pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (en0) v1_reg <= s_valid;
            if (en1) v2_reg <= v1_reg;
            // only draws go past the palette stage
            if (en2) v3_reg <= v2_reg && s2_reg.op == OP_DRAW;
            if (en3) out_v_reg <= v3_reg;
        end
    end

    // ---- pipeline payload
    always_ff @(posedge aclk) begin
        if (en0) s1_reg <= in_item;
        if (en1) begin
            s2_reg     <= s1_reg;
            s2_src_reg <= col_rdata;
        end
        if (en2) s3_bg_reg <= s2_reg.bg;
        if (en3) pixel_reg <= pixel_next;
    end

    assign m_valid = out_v_reg;
    assign m_pixel = pixel_reg;

    // ---- checks
    `CPBS_ASSERT_NXT(a_pos_restart, aclk, aresetn,
        acc && s_operation == OP_DRAW && s_first_of_run, pos_reg == $past(step_reg))
    `CPBS_ASSERT_IMP(a_full_stall, aclk, aresetn,
        out_v_reg && !m_ready && v1_reg && v2_reg && v3_reg, !s_ready)
    `CPBS_ASSERT_IMP(a_result_source, aclk, aresetn, $rose(out_v_reg), $past(v3_reg))

endmodule

[rtl/core/cpbs_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module cpbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
